// File: rtl/button_press_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared widths, event codes, register map and configuration type.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int CFG_BITS      = 24;
    localparam int ADDR_BITS     = 4;
    localparam int DATA_BITS     = 32;
    localparam int OUT_BITS      = 8;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 24'd40000;
    localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RST = 24'd350000;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 24'd1200000;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_DOUBLE_GAP = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_time;
        logic [CFG_BITS-1:0] double_gap_time;
        logic [CFG_BITS-1:0] long_press_time;
    } t_cfg;

endpackage

// File: rtl/bpc_regs.sv
// ----------------------------------------------------------------------------
// Button press classifier register file
// APB-style write and read access to the three timing registers.
// ----------------------------------------------------------------------------
module bpc_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [bpc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [bpc_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output bpc_pkg::t_cfg                  o_cfg
);

    bpc_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= bpc_pkg::DEBOUNCE_RST;
            r_cfg.double_gap_time <= bpc_pkg::DOUBLE_GAP_RST;
            r_cfg.long_press_time <= bpc_pkg::LONG_PRESS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bpc_pkg::REG_DEBOUNCE:   r_cfg.debounce_time   <= pwdata[bpc_pkg::CFG_BITS-1:0];
                bpc_pkg::REG_DOUBLE_GAP: r_cfg.double_gap_time <= pwdata[bpc_pkg::CFG_BITS-1:0];
                bpc_pkg::REG_LONG_PRESS: r_cfg.long_press_time <= pwdata[bpc_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bpc_pkg::REG_DEBOUNCE:
                prdata = bpc_pkg::DATA_BITS'(r_cfg.debounce_time);
            bpc_pkg::REG_DOUBLE_GAP:
                prdata = bpc_pkg::DATA_BITS'(r_cfg.double_gap_time);
            bpc_pkg::REG_LONG_PRESS:
                prdata = bpc_pkg::DATA_BITS'(r_cfg.long_press_time);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: rtl/button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// Button press classifier
// Debounces polls of an active-low button and reports short, double and
// long presses, one event code per poll.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         poll request: pin level, timestamp
//  m_axis    out        event code for each poll
//  apb       in/out     debounce, double gap and long press times
//
//  The state update of a poll is done between the input register and the
//  result register, which holds its event; one poll is accepted per cycle
//  while m_axis does not stall. A result held by m_axis_tready low stalls
//  the classifier, but an empty input register still takes a poll. Reset is
//  synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
`include "button_press_classifier_top_assert.svh"

module button_press_classifier_top #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [0] pin_level, [TIME_BITS:1] time_now, zero padded above
    input  logic [((TIME_BITS+8)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] event_code, zero padded above
    output logic [bpc_pkg::OUT_BITS-1:0]   m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [bpc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [bpc_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    bpc_pkg::t_cfg cfg;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input stage.
    logic                 r_in_valid;
    logic                 r_in_level;
    logic [TIME_BITS-1:0] r_in_time;

    // Classifier state.
    logic                 r_last_raw;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_raw_chg_time;
    logic [TIME_BITS-1:0] r_press_time;
    logic [TIME_BITS-1:0] r_release_time;
    logic                 r_short_wait;
    logic                 r_long_rep;

    // Result stage.
    logic                 r_out_valid;
    bpc_pkg::t_event      r_out_event;

    logic                 n_last_raw;
    logic                 n_stable;
    logic [TIME_BITS-1:0] n_raw_chg_time;
    logic [TIME_BITS-1:0] n_press_time;
    logic [TIME_BITS-1:0] n_release_time;
    logic                 n_short_wait;
    logic                 n_long_rep;
    bpc_pkg::t_event      n_event;

    logic                 advance;
    logic                 fire;

    logic [TIME_BITS-1:0] now;
    logic                 raw;
    logic [TIME_BITS-1:0] d_deb;
    logic [TIME_BITS-1:0] d_long;
    logic [TIME_BITS-1:0] d_gap;
    logic                 deb_old;
    logic                 long_old;
    logic                 gap_old;
    logic                 raw_chg;
    logic                 deb_ok;
    logic                 press_acc;
    logic                 release_set;
    logic                 done;
    logic                 long_hit;
    logic                 gap_hit;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = bpc_pkg::OUT_BITS'(r_out_event);

    assign now = r_in_time;
    assign raw = r_in_level;

    // Elapsed-time tests against the stored stamps; a negative
    // difference is below every threshold.
    assign d_deb    = now - r_raw_chg_time;
    assign d_long   = now - r_press_time;
    assign d_gap    = now - r_release_time;
    assign deb_old  = (now >= r_raw_chg_time) && (d_deb >= TIME_BITS'(cfg.debounce_time));
    assign long_old = (now >= r_press_time) && (d_long >= TIME_BITS'(cfg.long_press_time));
    assign gap_old  = (now >= r_release_time) && (d_gap > TIME_BITS'(cfg.double_gap_time));

    always_comb begin
        n_last_raw     = r_last_raw;
        n_stable       = r_stable;
        n_raw_chg_time = r_raw_chg_time;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_short_wait   = r_short_wait;
        n_long_rep     = r_long_rep;
        n_event        = bpc_pkg::EV_NONE;
        press_acc      = 1'b0;
        release_set    = 1'b0;
        done           = 1'b0;

        raw_chg = (raw != r_last_raw);
        if (raw_chg) begin
            n_last_raw     = raw;
            n_raw_chg_time = now;
        end

        // A change stamped on this very poll has zero elapsed time.
        deb_ok = raw_chg ? (cfg.debounce_time == '0) : deb_old;

        if ((raw != r_stable) && deb_ok) begin
            n_stable = raw;
            if (!raw) begin
                n_press_time = now;
                n_long_rep   = 1'b0;
                press_acc    = 1'b1;
            end else if (r_long_rep || long_old) begin
                // Release of a long press gives no event.
                n_short_wait   = 1'b0;
                n_release_time = '0;
                n_long_rep     = 1'b1;
                done           = 1'b1;
            end else if (r_short_wait && (r_release_time != '0) && !gap_old) begin
                n_short_wait   = 1'b0;
                n_release_time = '0;
                n_event        = bpc_pkg::EV_DOUBLE;
                done           = 1'b1;
            end else begin
                n_short_wait   = 1'b1;
                n_release_time = now;
                release_set    = 1'b1;
            end
        end

        long_hit = press_acc ? (cfg.long_press_time == '0) : long_old;
        gap_hit  = release_set ? 1'b0 : gap_old;

        if (!done && !n_stable && !n_long_rep && (n_press_time != '0) && long_hit) begin
            n_long_rep     = 1'b1;
            n_short_wait   = 1'b0;
            n_release_time = '0;
            n_event        = bpc_pkg::EV_LONG;
        end else if (!done && n_short_wait && n_stable && (n_release_time != '0)
                     && gap_hit) begin
            n_short_wait   = 1'b0;
            n_release_time = '0;
            n_event        = bpc_pkg::EV_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
            r_in_time  <= s_axis_tdata[TIME_BITS:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b1;
            r_stable       <= 1'b1;
            r_raw_chg_time <= '0;
            r_press_time   <= '0;
            r_release_time <= '0;
            r_short_wait   <= 1'b0;
            r_long_rep     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_event    <= bpc_pkg::EV_NONE;
        end else if (fire) begin
            r_last_raw     <= n_last_raw;
            r_stable       <= n_stable;
            r_raw_chg_time <= n_raw_chg_time;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_short_wait   <= n_short_wait;
            r_long_rep     <= n_long_rep;
            r_out_valid    <= 1'b1;
            r_out_event    <= n_event;
        end else if (m_axis_tready) begin
            r_out_valid    <= 1'b0;
        end
    end

    `BPC_ASSERT_NEXT(a_long_marks_reported, fire && (n_event == bpc_pkg::EV_LONG), r_long_rep, "long event without long flag set")
    `BPC_ASSERT_NEXT(a_event_clears_wait, fire && (n_event != bpc_pkg::EV_NONE), !r_short_wait && (r_release_time == '0), "event left a short press waiting")
    `BPC_ASSERT_NEXT(a_stall_holds_state, !advance, $stable(r_stable) && $stable(r_short_wait) && $stable(r_long_rep), "classifier state moved during a stall")
    `BPC_ASSERT_NOW(a_stall_blocks_input, r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready, "input taken while both stages are full")

endmodule
